@@ rtl/srd_pkg.sv @@
// Shared types and constants for the sensor record deframer.
`default_nettype none

package srd_pkg;

    // Record type codes
    localparam logic [7:0] TYPE_IMAGE    = 8'h00;
    localparam logic [7:0] TYPE_GYRO     = 8'h01;
    localparam logic [7:0] TYPE_ACCEL    = 8'h02;
    localparam logic [7:0] TYPE_MAG      = 8'h03;
    localparam logic [7:0] TYPE_ALT      = 8'h04;
    localparam logic [7:0] TYPE_GPS      = 8'h05;
    localparam logic [7:0] TYPE_ATTITUDE = 8'h11;
    localparam logic [7:0] TYPE_GRAVITY  = 8'h12;

    // Image field numbers
    localparam logic [2:0] IMG_WIDTH  = 3'd0;
    localparam logic [2:0] IMG_HEIGHT = 3'd1;
    localparam logic [2:0] IMG_PIXEL  = 3'd2;

    localparam logic [2:0] LAST_STAMP_BYTE = 3'd7;
    localparam logic [3:0] IMG_FIELD_BYTES = 4'd4;
    localparam logic [3:0] WORD_BYTES      = 4'd8;

    typedef enum logic [1:0] {
        PH_TYPE   = 2'd0,
        PH_STAMP  = 2'd1,
        PH_FIELDS = 2'd2,
        PH_PIXELS = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0]  record_type;
        logic [2:0]  field_index;
        logic [63:0] stamp_bits;
        logic [63:0] field_value;
        logic        last_of_record;
        logic        unknown_type;
    } srd_result_t;

    // Number of 64-bit fields for a non-image type; zero means unknown.
    function automatic logic [2:0] field_count(input logic [7:0] t);
        logic [2:0] cnt;
        begin
            case (t)
                TYPE_GYRO, TYPE_ACCEL, TYPE_MAG, TYPE_GRAVITY: cnt = 3'd3;
                TYPE_ALT:                                      cnt = 3'd2;
                TYPE_GPS:                                      cnt = 3'd5;
                TYPE_ATTITUDE:                                 cnt = 3'd4;
                default:                                       cnt = 3'd0;
            endcase
            field_count = cnt;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/srd_in_stage.sv @@
// Input register for the byte stream.
`default_nettype none

module srd_in_stage
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       advance,
    output logic            held_valid,
    output logic [7:0]      held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign byte_ready = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_valid && byte_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            byte_reg <= data_byte;
        end
    end

endmodule

`default_nettype wire

@@ rtl/srd_parser.sv @@
// Record parser: phase tracking, field assembly and result formation.
`default_nettype none

module srd_parser import srd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic [7:0] cur_byte,
    output logic            emit,
    output srd_result_t     result
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  bif_reg, bif_next;
    logic [2:0]  fnum_reg, fnum_next;
    logic [7:0]  type_reg, type_next;
    logic [63:0] stamp_reg, stamp_next;
    logic [63:0] asm_reg, asm_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] pixels_reg, pixels_next;
    logic [31:0] prod_reg, prod_next;

    logic        is_image;
    logic [2:0]  cnt;
    logic [3:0]  fsize;
    logic [63:0] asm_fill;
    logic [31:0] part_prod;
    logic [31:0] prod_sum;
    logic [31:0] pixels_dec;

    assign is_image  = (type_reg == TYPE_IMAGE);
    assign cnt       = field_count(type_reg);
    assign fsize     = is_image ? IMG_FIELD_BYTES : WORD_BYTES;
    assign part_prod = width_reg * {24'd0, cur_byte};
    // running width*height, one height byte at a time
    assign prod_sum  = prod_reg + (part_prod << {bif_reg[1:0], 3'b000});
    assign pixels_dec = (pixels_reg != 32'd0) ? (pixels_reg - 32'd1) : pixels_reg;

    always_comb
    begin
        asm_fill = asm_reg;
        asm_fill[bif_reg*8 +: 8] = cur_byte;
    end

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        bif_next    = bif_reg;
        fnum_next   = fnum_reg;
        type_next   = type_reg;
        stamp_next  = stamp_reg;
        asm_next    = asm_reg;
        width_next  = width_reg;
        pixels_next = pixels_reg;
        prod_next   = prod_reg;
        if (advance)
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    type_next  = cur_byte;
                    stamp_next = 64'd0;
                    bif_next   = 3'd0;
                    fnum_next  = 3'd0;
                    asm_next   = 64'd0;
                    phase_next = PH_STAMP;
                end
                PH_STAMP:
                begin
                    stamp_next[bif_reg*8 +: 8] = cur_byte;
                    if (bif_reg != LAST_STAMP_BYTE)
                    begin
                        bif_next = bif_reg + 3'd1;
                    end
                    else
                    begin
                        bif_next  = 3'd0;
                        fnum_next = 3'd0;
                        asm_next  = 64'd0;
                        prod_next = 32'd0;
                        if (!is_image && cnt == 3'd0)
                        begin
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            phase_next = PH_FIELDS;
                        end
                    end
                end
                PH_FIELDS:
                begin
                    if (is_image && fnum_reg != IMG_WIDTH)
                    begin
                        prod_next = prod_sum;
                    end
                    if ({1'b0, bif_reg} + 4'd1 < fsize)
                    begin
                        bif_next = bif_reg + 3'd1;
                        asm_next = asm_fill;
                    end
                    else
                    begin
                        asm_next = 64'd0;
                        bif_next = 3'd0;
                        if (is_image)
                        begin
                            if (fnum_reg == IMG_WIDTH)
                            begin
                                width_next = asm_fill[31:0];
                                fnum_next  = IMG_HEIGHT;
                                prod_next  = 32'd0;
                            end
                            else if (prod_sum == 32'd0)
                            begin
                                phase_next = PH_TYPE;
                            end
                            else
                            begin
                                pixels_next = prod_sum;
                                phase_next  = PH_PIXELS;
                            end
                        end
                        else if ({1'b0, fnum_reg} + 4'd1 >= {1'b0, cnt})
                        begin
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            fnum_next = fnum_reg + 3'd1;
                        end
                    end
                end
                PH_PIXELS:
                begin
                    pixels_next = pixels_dec;
                    if (pixels_dec == 32'd0)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                default:
                begin
                    phase_next = PH_TYPE;
                end
            endcase
        end
    end

    // result
    always_comb
    begin
        emit                  = 1'b0;
        result.record_type    = type_reg;
        result.field_index    = fnum_reg;
        result.stamp_bits     = stamp_reg;
        result.field_value    = asm_fill;
        result.last_of_record = 1'b0;
        result.unknown_type   = 1'b0;
        case (phase_reg)
            PH_TYPE:
            begin
                emit = 1'b0;
            end
            PH_STAMP:
            begin
                result.stamp_bits = stamp_next;
                if (bif_reg == LAST_STAMP_BYTE && !is_image && cnt == 3'd0)
                begin
                    emit                  = advance;
                    result.field_index    = 3'd0;
                    result.field_value    = 64'd0;
                    result.last_of_record = 1'b1;
                    result.unknown_type   = 1'b1;
                end
            end
            PH_FIELDS:
            begin
                if ({1'b0, bif_reg} + 4'd1 >= fsize)
                begin
                    emit = advance;
                    if (is_image)
                    begin
                        if (fnum_reg == IMG_WIDTH)
                        begin
                            result.field_index = IMG_WIDTH;
                        end
                        else
                        begin
                            result.field_index    = IMG_HEIGHT;
                            result.last_of_record = (prod_sum == 32'd0);
                        end
                    end
                    else
                    begin
                        result.last_of_record = ({1'b0, fnum_reg} + 4'd1 >= {1'b0, cnt});
                    end
                end
            end
            PH_PIXELS:
            begin
                emit                  = advance;
                result.field_index    = IMG_PIXEL;
                result.field_value    = {56'd0, cur_byte};
                result.last_of_record = (pixels_dec == 32'd0);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            bif_reg    <= 3'd0;
            fnum_reg   <= 3'd0;
            type_reg   <= 8'd0;
            stamp_reg  <= 64'd0;
            asm_reg    <= 64'd0;
            width_reg  <= 32'd0;
            pixels_reg <= 32'd0;
            prod_reg   <= 32'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            bif_reg    <= bif_next;
            fnum_reg   <= fnum_next;
            type_reg   <= type_next;
            stamp_reg  <= stamp_next;
            asm_reg    <= asm_next;
            width_reg  <= width_next;
            pixels_reg <= pixels_next;
            prod_reg   <= prod_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/srd_out_stage.sv @@
// Result register toward the output channel.
`default_nettype none

module srd_out_stage import srd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire srd_result_t  result_in,
    output logic              slot_free,
    output logic              result_valid,
    input  wire logic         result_ready,
    output srd_result_t       result_out
);

    logic        valid_reg;
    logic        valid_next;
    srd_result_t data_reg;

    assign slot_free    = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result_out   = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sensor_record_deframer.sv @@
// Top level of the sensor record deframer.
//
//   channel   direction   handshake                    payload
//   byte      in          byte_valid / byte_ready      data_byte
//   result    out         result_valid / result_ready  record_type, field_index,
//                                                      stamp_bits, field_value,
//                                                      last_of_record, unknown_type
//
// One byte per cycle sustained while result_ready is high. Each byte is held in
// the input register and parsed from there; its result (if any) is loaded into
// the output register as the byte leaves the input register. Reset puts the
// parser at the type byte of a new record with all parser registers clear. A
// stalled result holds the parser; the input register takes at most one more byte.
`default_nettype none

module sensor_record_deframer import srd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_ready,
    input  wire logic [7:0]  data_byte,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [7:0]       record_type,
    output logic [2:0]       field_index,
    output logic [63:0]      stamp_bits,
    output logic [63:0]      field_value,
    output logic             last_of_record,
    output logic             unknown_type
);

    logic        held_valid;
    logic [7:0]  held_byte;
    logic        slot_free;
    logic        advance;
    logic        emit;
    srd_result_t parsed;
    srd_result_t result_q;

    assign advance = held_valid && slot_free;

    srd_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .data_byte  (data_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    srd_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cur_byte (held_byte),
        .emit     (emit),
        .result   (parsed)
    );

    srd_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (emit),
        .result_in    (parsed),
        .slot_free    (slot_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_out   (result_q)
    );

    assign record_type    = result_q.record_type;
    assign field_index    = result_q.field_index;
    assign stamp_bits     = result_q.stamp_bits;
    assign field_value    = result_q.field_value;
    assign last_of_record = result_q.last_of_record;
    assign unknown_type   = result_q.unknown_type;

endmodule

`default_nettype wire

@@ verif/srd_checker.sv @@
// Checker for the sensor record deframer: predicts results per accepted byte and compares them.
`timescale 1ns / 100ps
`default_nettype none

module srd_checker import srd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    input  wire logic        byte_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        result_valid,
    input  wire logic        result_ready,
    input  wire logic [7:0]  record_type,
    input  wire logic [2:0]  field_index,
    input  wire logic [63:0] stamp_bits,
    input  wire logic [63:0] field_value,
    input  wire logic        last_of_record,
    input  wire logic        unknown_type,
    output int               mismatches,
    output int               pending
);

    phase_t      phase;
    logic [2:0]  byte_pos;
    logic [2:0]  field_num;
    logic [7:0]  rec_type;
    logic [63:0] stamp_acc;
    logic [63:0] word_acc;
    logic [31:0] img_width;
    logic [31:0] pixels_left;
    int          err_count;

    srd_result_t expected_results[$];

    function automatic int word_fields(input logic [7:0] t);
        case (t)
            TYPE_GYRO, TYPE_ACCEL, TYPE_MAG, TYPE_GRAVITY: return 3;
            TYPE_ALT:                                      return 2;
            TYPE_GPS:                                      return 5;
            TYPE_ATTITUDE:                                 return 4;
            default:                                       return 0;
        endcase
    endfunction

    task automatic queue_result(input logic [2:0] idx, input logic [63:0] val,
                                input logic last, input logic unk);
        srd_result_t r;
        r.record_type    = rec_type;
        r.field_index    = idx;
        r.stamp_bits     = stamp_acc;
        r.field_value    = val;
        r.last_of_record = last;
        r.unknown_type   = unk;
        expected_results.push_back(r);
    endtask

    task automatic predict_byte(input logic [7:0] b);
        logic [63:0] shifted;
        int          fsize;
        logic [31:0] prod;
        logic        last;
        shifted = {56'd0, b} << (8 * byte_pos);
        case (phase)
            PH_TYPE:
            begin
                rec_type  = b;
                stamp_acc = '0;
                word_acc  = '0;
                byte_pos  = '0;
                field_num = '0;
                phase     = PH_STAMP;
            end
            PH_STAMP:
            begin
                stamp_acc |= shifted;
                if (byte_pos != LAST_STAMP_BYTE)
                begin
                    byte_pos++;
                end
                else
                begin
                    byte_pos  = '0;
                    field_num = '0;
                    word_acc  = '0;
                    if (rec_type != TYPE_IMAGE && word_fields(rec_type) == 0)
                    begin
                        queue_result(3'd0, 64'd0, 1'b1, 1'b1);
                        phase = PH_TYPE;
                    end
                    else
                    begin
                        phase = PH_FIELDS;
                    end
                end
            end
            PH_FIELDS:
            begin
                fsize = (rec_type == TYPE_IMAGE) ? int'(IMG_FIELD_BYTES) : int'(WORD_BYTES);
                word_acc |= shifted;
                if (int'(byte_pos) + 1 < fsize)
                begin
                    byte_pos++;
                end
                else
                begin
                    byte_pos = '0;
                    if (rec_type == TYPE_IMAGE)
                    begin
                        if (field_num == IMG_WIDTH)
                        begin
                            img_width = word_acc[31:0];
                            field_num = IMG_HEIGHT;
                            queue_result(IMG_WIDTH, word_acc, 1'b0, 1'b0);
                        end
                        else
                        begin
                            // product wraps to 32 bits; zero means no pixels
                            prod = img_width * word_acc[31:0];
                            if (prod == 32'd0)
                            begin
                                queue_result(IMG_HEIGHT, word_acc, 1'b1, 1'b0);
                                phase = PH_TYPE;
                            end
                            else
                            begin
                                pixels_left = prod;
                                queue_result(IMG_HEIGHT, word_acc, 1'b0, 1'b0);
                                phase = PH_PIXELS;
                            end
                        end
                    end
                    else
                    begin
                        last = (int'(field_num) + 1 >= word_fields(rec_type));
                        queue_result(field_num, word_acc, last, 1'b0);
                        if (last)
                            phase = PH_TYPE;
                        else
                            field_num++;
                    end
                    word_acc = '0;
                end
            end
            default:
            begin
                if (pixels_left != 32'd0)
                    pixels_left--;
                if (pixels_left == 32'd0)
                begin
                    queue_result(IMG_PIXEL, {56'd0, b}, 1'b1, 1'b0);
                    phase = PH_TYPE;
                end
                else
                begin
                    queue_result(IMG_PIXEL, {56'd0, b}, 1'b0, 1'b0);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        srd_result_t want;
        if (!rst_n)
        begin
            phase       = PH_TYPE;
            byte_pos    = '0;
            field_num   = '0;
            rec_type    = '0;
            stamp_acc   = '0;
            word_acc    = '0;
            img_width   = '0;
            pixels_left = '0;
            err_count   = 0;
            expected_results.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            // a byte taken at this edge cannot produce the result taken at the same edge
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual type %0h field %0d",
                             $time, record_type, field_index);
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("record_type", {56'd0, want.record_type}, {56'd0, record_type});
                    check_field("field_index", {61'd0, want.field_index}, {61'd0, field_index});
                    check_field("stamp_bits", want.stamp_bits, stamp_bits);
                    check_field("field_value", want.field_value, field_value);
                    check_field("last_of_record", {63'd0, want.last_of_record},
                                {63'd0, last_of_record});
                    check_field("unknown_type", {63'd0, want.unknown_type},
                                {63'd0, unknown_type});
                end
            end
            if (byte_valid && byte_ready)
                predict_byte(data_byte);
            mismatches <= err_count;
            pending    <= expected_results.size();
        end
    end

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Testbench top for the sensor record deframer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none

module tb_top import srd_pkg::*;
;

    localparam int TARGET_BYTES = 1950;
    localparam int QUIET_AFTER  = 1750;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_ready;
    logic [7:0]  data_byte;
    logic        result_valid;
    logic        result_ready;
    logic [7:0]  record_type;
    logic [2:0]  field_index;
    logic [63:0] stamp_bits;
    logic [63:0] field_value;
    logic        last_of_record;
    logic        unknown_type;
    int          mismatches;
    int          pending;

    int          bytes_sent;
    int          cycle_count;
    bit          quiet;
    bit          idle_on;

    sensor_record_deframer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .data_byte      (data_byte),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .record_type    (record_type),
        .field_index    (field_index),
        .stamp_bits     (stamp_bits),
        .field_value    (field_value),
        .last_of_record (last_of_record),
        .unknown_type   (unknown_type)
    );

    srd_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .data_byte      (data_byte),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .record_type    (record_type),
        .field_index    (field_index),
        .stamp_bits     (stamp_bits),
        .field_value    (field_value),
        .last_of_record (last_of_record),
        .unknown_type   (unknown_type),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: ready bursts with random stalls, none near the end
    initial
    begin
        result_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge clk);
            if (!quiet && $urandom_range(0, 3) != 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return {64{1'b1}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic bit is_known(input logic [7:0] t);
        case (t)
            TYPE_IMAGE, TYPE_GYRO, TYPE_ACCEL, TYPE_MAG, TYPE_ALT,
            TYPE_GPS, TYPE_ATTITUDE, TYPE_GRAVITY: return 1'b1;
            default:                               return 1'b0;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (!quiet && idle_on && $urandom_range(0, 5) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic put_le(input logic [63:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            send_byte(v[8*i +: 8]);
    endtask

    task automatic send_header(input logic [7:0] t, input logic [63:0] stamp);
        idle_on = ($urandom_range(0, 3) != 0);
        send_byte(t);
        put_le(stamp, 8);
    endtask

    // nsend below the type's field count leaves the record unfinished
    task automatic send_words(input logic [7:0] t, input logic [63:0] stamp,
                              input int nsend, input logic [63:0] fill, input bit use_fill);
        send_header(t, stamp);
        for (int i = 0; i < nsend; i++)
            put_le(use_fill ? fill : rand_word(), 8);
    endtask

    task automatic send_image(input logic [63:0] stamp, input logic [31:0] w,
                              input logic [31:0] h);
        logic [31:0] npix;
        npix = w * h;
        send_header(TYPE_IMAGE, stamp);
        put_le({32'd0, w}, 4);
        put_le({32'd0, h}, 4);
        for (logic [31:0] i = 0; i < npix; i++)
            send_byte(8'($urandom));
    endtask

    task automatic send_random_word_record();
        logic [7:0] t;
        int         nf;
        case ($urandom_range(0, 6))
            0:       begin t = TYPE_GYRO;     nf = 3; end
            1:       begin t = TYPE_ACCEL;    nf = 3; end
            2:       begin t = TYPE_MAG;      nf = 3; end
            3:       begin t = TYPE_ALT;      nf = 2; end
            4:       begin t = TYPE_GPS;      nf = 5; end
            5:       begin t = TYPE_ATTITUDE; nf = 4; end
            default: begin t = TYPE_GRAVITY;  nf = 3; end
        endcase
        send_words(t, rand_word(), nf, 64'd0, 1'b0);
    endtask

    task automatic send_random_image();
        logic [31:0] w;
        logic [31:0] h;
        int          k;
        case ($urandom_range(0, 9))
            6:
            begin
                w = 32'd0;
                h = $urandom;
            end
            7:
            begin
                w = $urandom;
                h = 32'd0;
            end
            8:
            begin
                // power-of-two pair whose product wraps to zero
                k = $urandom_range(1, 31);
                w = 32'd1 << k;
                h = 32'd1 << (32 - k);
            end
            9:
            begin
                // all-ones width, product wraps to a small count
                w = 32'hFFFF_FFFF;
                h = -32'($urandom_range(1, 4));
            end
            default:
            begin
                w = $urandom_range(1, 4);
                h = $urandom_range(1, 4);
            end
        endcase
        send_image(rand_word(), w, h);
    endtask

    task automatic send_random_unknown();
        logic [7:0] t;
        t = 8'($urandom);
        while (is_known(t))
            t = 8'($urandom);
        send_words(t, rand_word(), 0, 64'd0, 1'b0);
    endtask

    initial
    begin
        int pick;
        rst_n       = 1'b0;
        byte_valid  = 1'b0;
        data_byte   = 8'd0;
        bytes_sent  = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        idle_on     = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: every type, field extremes, unknown types, image corner cases
        send_words(TYPE_GYRO, 64'd0, 3, 64'd0, 1'b1);
        send_words(TYPE_ACCEL, {64{1'b1}}, 3, {64{1'b1}}, 1'b1);
        send_words(TYPE_MAG, rand_word(), 3, 64'd0, 1'b0);
        send_words(TYPE_ALT, rand_word(), 2, 64'd0, 1'b0);
        send_words(TYPE_GPS, rand_word(), 5, 64'd0, 1'b0);
        send_words(TYPE_ATTITUDE, rand_word(), 4, 64'd0, 1'b0);
        send_words(TYPE_GRAVITY, rand_word(), 3, 64'd0, 1'b0);
        send_image(rand_word(), 32'd2, 32'd3);
        send_image(rand_word(), 32'd0, 32'hFFFF_FFFF);
        send_image(rand_word(), 32'hFFFF_FFFF, 32'd0);
        send_image(rand_word(), 32'h8000_0000, 32'd2);
        send_image({64{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_words(8'hFF, {64{1'b1}}, 0, 64'd0, 1'b0);
        send_words(8'h06, rand_word(), 0, 64'd0, 1'b0);
        send_words(8'h10, rand_word(), 0, 64'd0, 1'b0);
        send_words(8'h13, rand_word(), 0, 64'd0, 1'b0);

        while (bytes_sent < TARGET_BYTES)
        begin
            if (bytes_sent >= QUIET_AFTER)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_random_word_record();
            else if (pick < 82)
                send_random_image();
            else
                send_random_unknown();
        end

        // stream ends in the middle of a record
        send_words(TYPE_GPS, rand_word(), 2, 64'd0, 1'b0);
        send_byte(8'($urandom));

        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/srd_pkg.sv
rtl/srd_in_stage.sv
rtl/srd_parser.sv
rtl/srd_out_stage.sv
rtl/sensor_record_deframer.sv
verif/srd_checker.sv
verif/tb_top.sv
